>>> hw/rtl/u8tok_pkg.sv
// Shared types, constants and byte classifiers for the UTF-8 word tokenizer.
`timescale 1ns / 1ps
package u8tok_pkg;

    localparam int unsigned POS_W = 16;
    localparam int unsigned LEN_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_LIMIT = '1;  // largest offset; positions saturate here

    localparam int unsigned FIFO_AW = 2;
    localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [1:0] MODE_SKIP  = 2'd0;
    localparam logic [1:0] MODE_ASCII = 2'd1;
    localparam logic [1:0] MODE_UTF   = 2'd2;
    localparam logic [1:0] MODE_ERROR = 2'd3;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [7:0] UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_result;

    function automatic logic is_alnum(input logic [7:0] b);
        return b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    // Character length from a lead byte; 0 for a bad lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & 8'hE0) == 8'hC0) len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
        else if ((b & 8'hFC) == 8'hF8) len = 3'd5;
        else if ((b & 8'hFE) == 8'hFC) len = 3'd6;
        return len;
    endfunction

endpackage

>>> hw/rtl/u8tok_out_fifo.sv
// Small result queue: takes up to two items per cycle, delivers one per cycle while i_ready is high.
`timescale 1ns / 1ps
module u8tok_out_fifo
    import u8tok_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  logic    i_push1,
    input  t_result i_data0,
    input  t_result i_data1,
    output logic    o_space2,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;
    logic [FIFO_AW:0]     n_count;
    logic [FIFO_AW-1:0]   n_wr_ptr;
    logic [FIFO_AW-1:0]   wr_ptr1;
    logic                 pop;

    assign pop      = (r_count != '0) && i_ready;
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_space2 = (r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign wr_ptr1  = r_wr_ptr + FIFO_AW'(1);

    always_comb begin
        n_count  = r_count + {{FIFO_AW{1'b0}}, i_push0} + {{FIFO_AW{1'b0}}, i_push1}
                   - {{FIFO_AW{1'b0}}, pop};
        n_wr_ptr = r_wr_ptr + {{(FIFO_AW-1){1'b0}}, i_push0} + {{(FIFO_AW-1){1'b0}}, i_push1};
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wr_ptr] <= i_data0;
        if (i_push1) r_mem[wr_ptr1] <= i_data1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (pop) r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
        end
    end

endmodule

>>> hw/rtl/utf8_word_tokenizer.sv
// UTF-8 word tokenizer: byte stream in, token offset/length results out.
// Takes one byte per cycle and reports each token (an ASCII word that starts with a letter or
// digit, or one multi-byte UTF-8 character) as its start offset and length, plus an error
// result for a bad lead byte or a character cut off by the end of the text. A byte that
// closes an ASCII word and itself opens a bad or cut-off character gives two results;
// results pass through a four-entry queue, and o_in_ready drops while fewer than two
// entries are free, so with the output side taking one result per cycle the block runs at
// one byte per cycle. Offsets saturate at 65535 in over-long texts. Results reach the
// outputs through the registered queue.
`timescale 1ns / 1ps
module utf8_word_tokenizer
    import u8tok_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_text_end,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_result_kind,
    output logic [POS_W-1:0] o_token_start,
    output logic [LEN_W-1:0] o_token_length,
    output logic             o_last_of_run
);

    logic [1:0]       r_mode, n_mode;
    logic [2:0]       r_owed, n_owed;
    logic [POS_W-1:0] r_start, n_start;
    logic [POS_W-1:0] r_pos, n_pos;

    logic       accept;
    logic       space2;
    logic       a_v, b_v;
    t_result    a_res, b_res, slot0, slot1;
    t_result    q_out;
    logic       try_start;
    logic [2:0] lead_len;
    logic [LEN_W-1:0] len_incl, len_excl;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = space2;
    assign lead_len   = lead_length(i_data_byte);
    assign len_incl   = {1'b0, r_pos} + LEN_W'(1) - {1'b0, r_start};
    assign len_excl   = {1'b0, r_pos} - {1'b0, r_start};

    always_comb begin
        n_mode    = r_mode;
        n_owed    = r_owed;
        n_start   = r_start;
        n_pos     = r_pos;
        try_start = 1'b0;
        a_v       = 1'b0;
        b_v       = 1'b0;
        a_res     = '{kind: KIND_TOKEN, start: r_start, length: len_incl, last: 1'b1};
        b_res     = '{kind: KIND_TOKEN, start: r_pos, length: LEN_W'(1), last: 1'b1};

        case (r_mode)
            MODE_SKIP: try_start = 1'b1;
            MODE_ASCII: begin
                if (is_alnum(i_data_byte) || i_data_byte == UNDERSCORE) begin
                    a_v = i_text_end;
                end else begin
                    a_v          = 1'b1;
                    a_res.length = len_excl;
                    n_mode       = MODE_SKIP;
                    try_start    = 1'b1;
                end
            end
            MODE_UTF: begin
                n_owed = r_owed - 3'd1;
                if (n_owed == 3'd0) begin
                    a_v    = 1'b1;
                    n_mode = MODE_SKIP;
                end else if (i_text_end) begin
                    a_v          = 1'b1;
                    a_res.kind   = KIND_ERROR;
                    a_res.length = '0;
                end
            end
            default: ;  // error: ignore bytes until end of text
        endcase

        if (try_start) begin
            if (is_alnum(i_data_byte)) begin
                n_start = r_pos;
                n_mode  = MODE_ASCII;
                b_v     = i_text_end;
            end else if (i_data_byte[7]) begin
                n_start      = r_pos;
                b_res.kind   = KIND_ERROR;
                b_res.length = '0;
                if (lead_len == 3'd0) begin
                    b_v    = 1'b1;
                    n_mode = MODE_ERROR;
                end else begin
                    n_owed = lead_len - 3'd1;
                    n_mode = MODE_UTF;
                    b_v    = i_text_end;
                end
            end
        end

        if (i_text_end) begin
            n_mode = MODE_SKIP;
            n_owed = 3'd0;
            n_pos  = '0;
        end else if (r_pos < POS_LIMIT) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Pack the one or two results of this byte in order.
    always_comb begin
        slot0      = a_v ? a_res : b_res;
        slot0.last = !(a_v && b_v);
        slot1      = b_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SKIP;
            r_owed  <= 3'd0;
            r_start <= '0;
            r_pos   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_owed  <= n_owed;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

    u8tok_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (accept && (a_v || b_v)),
        .i_push1  (accept && a_v && b_v),
        .i_data0  (slot0),
        .i_data1  (slot1),
        .o_space2 (space2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (q_out)
    );

    assign o_result_kind  = q_out.kind;
    assign o_token_start  = q_out.start;
    assign o_token_length = q_out.length;
    assign o_last_of_run  = q_out.last;

endmodule
